// File: rtl/bba_pkg.sv
package bba_pkg;

   // Field widths of the request, response and csr ports
   localparam int ADDR_W   = 32;
   localparam int BYTES_W  = 16;
   localparam int COUNT_W  = 11;
   localparam int STATUS_W = 3;
   localparam int CSR_IDX_W = 2;

   // Pool geometry; the map is kept as rows of WORD_W occupancy bits.
   // MAX_BLOCKS is a power of two and a multiple of 2 * WORD_W.
   localparam int MAX_BLOCKS = 1024;
   localparam int IDX_W      = $clog2(MAX_BLOCKS);
   localparam int WORD_W     = 32;
   localparam int BIT_W      = $clog2(WORD_W);
   localparam int ROWS       = MAX_BLOCKS / WORD_W;
   localparam int ROW_W      = IDX_W - BIT_W;

   // Iteration counter of the shared arithmetic unit
   localparam int STEP_W = $clog2(ADDR_W);

   // Register reset values
   localparam logic [ADDR_W-1:0]  BASE_RESET  = '0;
   localparam logic [BYTES_W-1:0] BYTES_RESET = BYTES_W'(32);
   localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1024);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BASE  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_BYTES = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT = CSR_IDX_W'(2);

   // Request commands
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK           = 3'd0,
      ST_FULL         = 3'd1,
      ST_ZERO         = 3'd2,
      ST_OUTSIDE      = 3'd3,
      ST_MISALIGNED   = 3'd4,
      ST_ALREADY_FREE = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_ALLOC_RD,
      S_MUL_WAIT,
      S_DIV_WAIT,
      S_FREE_RD
   } state_type;

   typedef enum logic {
      OP_MUL,
      OP_DIV
   } arith_op_type;

   // Sequencer to arithmetic unit
   typedef struct packed {
      logic                start;
      arith_op_type        op;
      logic [ADDR_W-1:0]   a;
      logic [BYTES_W-1:0]  b;
   } arith_req_type;

   // Arithmetic unit to sequencer
   typedef struct packed {
      logic                done;
      logic [ADDR_W-1:0]   result;
      logic [BYTES_W-1:0]  rem;
   } arith_rsp_type;

   typedef struct packed {
      logic              en;
      logic [ROW_W-1:0]  row;
   } map_rd_type;

   typedef struct packed {
      logic              en;
      logic [ROW_W-1:0]  row;
      logic [WORD_W-1:0] data;
   } map_wr_type;

   // Block count clamped to the pool capacity
   function automatic logic [COUNT_W-1:0] eff_count(input logic [COUNT_W-1:0] n);
      logic [COUNT_W-1:0] lim;
      lim = COUNT_W'(MAX_BLOCKS);
      return (n > lim) ? lim : n;
   endfunction

   // Block size of zero acts as one byte
   function automatic logic [BYTES_W-1:0] eff_bytes(input logic [BYTES_W-1:0] b);
      return (b == '0) ? BYTES_W'(1) : b;
   endfunction

endpackage

// File: rtl/bitmap_block_allocator.sv
// Fixed-size block pool allocator with one occupancy bit per block.
// Request channel: a request (req_cmd, req_address) is taken on a clock edge
// where start is high and busy is low; busy stays high until the response.
// Response channel: rsp_strobe is high for one cycle with rsp_status,
// rsp_block_address and rsp_free_blocks; the receiver cannot stall it.
// Csr channel: csr_index / csr_wdata written when csr_valid and csr_ready
// are high; csr_ready is high while the block is idle. Index 0 is the pool
// base address, 1 the block size in bytes, 2 the block count. Any write to
// one of them frees every block at once (all row flags are cleared together).
// Path from accept to strobe: a pool-full allocate or a zero / below-base
// free answers straight from the check state; an allocate reads the map,
// then runs the shared shift-add multiplier for index * size; a free runs
// the shared restoring divider, and one not found outside or misaligned
// then does a map read-modify-write.
// The next request may be started in the cycle the strobe is shown.
// Reset (synchronous) restores base 0, size 32, count 1024 and an empty pool.
module bitmap_block_allocator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_cmd,
   input  logic [bba_pkg::ADDR_W-1:0]        req_address,
   output logic                              rsp_strobe,
   output logic [bba_pkg::STATUS_W-1:0]      rsp_status,
   output logic [bba_pkg::ADDR_W-1:0]        rsp_block_address,
   output logic [bba_pkg::COUNT_W-1:0]       rsp_free_blocks,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bba_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bba_pkg::ADDR_W-1:0]        csr_wdata
);

   bba_pkg::state_type                 state_ff, state_in;
   logic                               cmd_ff, cmd_in;
   logic [bba_pkg::ADDR_W-1:0]         addr_ff, addr_in;
   logic [bba_pkg::ROW_W-1:0]          row_ff, row_in;
   logic [bba_pkg::IDX_W-1:0]          idx_ff, idx_in;
   logic [bba_pkg::COUNT_W-1:0]        free_ff, free_in;
   logic [bba_pkg::ADDR_W-1:0]         base_ff, base_in;
   logic [bba_pkg::BYTES_W-1:0]        bytes_ff, bytes_in;
   logic [bba_pkg::COUNT_W-1:0]        count_ff, count_in;
   logic                               rsp_strobe_ff, rsp_strobe_in;
   bba_pkg::status_type                rsp_status_ff, rsp_status_in;
   logic [bba_pkg::ADDR_W-1:0]         rsp_addr_ff, rsp_addr_in;
   logic [bba_pkg::COUNT_W-1:0]        rsp_free_ff, rsp_free_in;

   bba_pkg::arith_req_type             arith_req;
   bba_pkg::arith_rsp_type             arith_rsp;
   bba_pkg::map_rd_type                map_rd;
   bba_pkg::map_wr_type                map_wr;
   logic                               map_clear;
   logic [bba_pkg::WORD_W-1:0]         map_rd_data;
   logic [bba_pkg::ROW_W-1:0]          map_free_row;

   logic [bba_pkg::COUNT_W-1:0]        cnt_eff;
   logic [bba_pkg::BYTES_W-1:0]        bytes_eff;
   logic [bba_pkg::COUNT_W-1:0]        new_count;
   logic [bba_pkg::BIT_W-1:0]          zero_bit;
   logic [bba_pkg::WORD_W-1:0]         bit_mask;
   logic [bba_pkg::IDX_W-1:0]          alloc_idx;

   bba_arith u_arith (
      .clock (clock),
      .reset (reset),
      .req   (arith_req),
      .rsp   (arith_rsp)
   );

   bba_map u_map (
      .clock    (clock),
      .reset    (reset),
      .clear    (map_clear),
      .rd       (map_rd),
      .wr       (map_wr),
      .rd_data  (map_rd_data),
      .free_row (map_free_row)
   );

   assign cnt_eff   = bba_pkg::eff_count(count_ff);
   assign bytes_eff = bba_pkg::eff_bytes(bytes_ff);
   assign busy      = (state_ff != bba_pkg::S_IDLE);
   assign csr_ready = (state_ff == bba_pkg::S_IDLE);

   // lowest clear bit of the row just read
   always_comb begin
      zero_bit = '0;
      for (int i = bba_pkg::WORD_W - 1; i >= 0; i--) begin
         if (!map_rd_data[i]) begin
            zero_bit = bba_pkg::BIT_W'(i);
         end
      end
   end

   assign alloc_idx = {row_ff, zero_bit};

   // sequencer: next state and datapath controls
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      addr_in       = addr_ff;
      row_in        = row_ff;
      idx_in        = idx_ff;
      free_in       = free_ff;
      base_in       = base_ff;
      bytes_in      = bytes_ff;
      count_in      = count_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_free_in   = rsp_free_ff;
      arith_req     = '0;
      map_rd        = '0;
      map_wr        = '0;
      map_clear     = 1'b0;
      new_count     = count_ff;
      bit_mask      = '0;

      // csr writes; any known register empties the pool
      if (csr_valid && csr_ready) begin
         case (csr_index)
            bba_pkg::CSR_BASE: begin
               base_in   = csr_wdata;
               map_clear = 1'b1;
            end
            bba_pkg::CSR_BYTES: begin
               bytes_in  = csr_wdata[bba_pkg::BYTES_W-1:0];
               map_clear = 1'b1;
            end
            bba_pkg::CSR_COUNT: begin
               count_in  = csr_wdata[bba_pkg::COUNT_W-1:0];
               new_count = csr_wdata[bba_pkg::COUNT_W-1:0];
               map_clear = 1'b1;
            end
            default: begin
               map_clear = 1'b0;
            end
         endcase
         if (map_clear) begin
            free_in = bba_pkg::eff_count(new_count);
         end
      end

      case (state_ff)
         bba_pkg::S_IDLE: begin
            if (start) begin
               cmd_in   = req_cmd;
               addr_in  = req_address;
               state_in = bba_pkg::S_CHECK;
            end
         end

         bba_pkg::S_CHECK: begin
            if (cmd_ff == bba_pkg::CMD_ALLOC) begin
               if (free_ff == '0) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = bba_pkg::ST_FULL;
                  rsp_addr_in   = '0;
                  rsp_free_in   = free_ff;
                  state_in      = bba_pkg::S_IDLE;
               end else begin
                  map_rd.en  = 1'b1;
                  map_rd.row = map_free_row;
                  row_in     = map_free_row;
                  state_in   = bba_pkg::S_ALLOC_RD;
               end
            end else if (addr_ff == '0) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = bba_pkg::ST_ZERO;
               rsp_addr_in   = '0;
               rsp_free_in   = free_ff;
               state_in      = bba_pkg::S_IDLE;
            end else if (addr_ff < base_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = bba_pkg::ST_OUTSIDE;
               rsp_addr_in   = '0;
               rsp_free_in   = free_ff;
               state_in      = bba_pkg::S_IDLE;
            end else begin
               // offset / size gives the index, the remainder the alignment
               arith_req.start = 1'b1;
               arith_req.op    = bba_pkg::OP_DIV;
               arith_req.a     = addr_ff - base_ff;
               arith_req.b     = bytes_eff;
               state_in        = bba_pkg::S_DIV_WAIT;
            end
         end

         bba_pkg::S_ALLOC_RD: begin
            bit_mask        = bba_pkg::WORD_W'(1) << zero_bit;
            map_wr.en       = 1'b1;
            map_wr.row      = row_ff;
            map_wr.data     = map_rd_data | bit_mask;
            idx_in          = alloc_idx;
            free_in         = free_ff - 1'b1;
            arith_req.start = 1'b1;
            arith_req.op    = bba_pkg::OP_MUL;
            arith_req.a     = bba_pkg::ADDR_W'(alloc_idx);
            arith_req.b     = bytes_eff;
            state_in        = bba_pkg::S_MUL_WAIT;
         end

         bba_pkg::S_MUL_WAIT: begin
            if (arith_rsp.done) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = bba_pkg::ST_OK;
               rsp_addr_in   = base_ff + arith_rsp.result;
               rsp_free_in   = free_ff;
               state_in      = bba_pkg::S_IDLE;
            end
         end

         bba_pkg::S_DIV_WAIT: begin
            if (arith_rsp.done) begin
               // quotient at or past the count means past the pool end
               if (arith_rsp.result >= bba_pkg::ADDR_W'(cnt_eff)) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = bba_pkg::ST_OUTSIDE;
                  rsp_addr_in   = '0;
                  rsp_free_in   = free_ff;
                  state_in      = bba_pkg::S_IDLE;
               end else if (arith_rsp.rem != '0) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = bba_pkg::ST_MISALIGNED;
                  rsp_addr_in   = '0;
                  rsp_free_in   = free_ff;
                  state_in      = bba_pkg::S_IDLE;
               end else begin
                  idx_in     = arith_rsp.result[bba_pkg::IDX_W-1:0];
                  map_rd.en  = 1'b1;
                  map_rd.row = arith_rsp.result[bba_pkg::IDX_W-1:bba_pkg::BIT_W];
                  state_in   = bba_pkg::S_FREE_RD;
               end
            end
         end

         bba_pkg::S_FREE_RD: begin
            bit_mask      = bba_pkg::WORD_W'(1) << idx_ff[bba_pkg::BIT_W-1:0];
            rsp_strobe_in = 1'b1;
            rsp_addr_in   = '0;
            state_in      = bba_pkg::S_IDLE;
            if ((map_rd_data & bit_mask) == '0) begin
               rsp_status_in = bba_pkg::ST_ALREADY_FREE;
               rsp_free_in   = free_ff;
            end else begin
               map_wr.en     = 1'b1;
               map_wr.row    = idx_ff[bba_pkg::IDX_W-1:bba_pkg::BIT_W];
               map_wr.data   = map_rd_data & ~bit_mask;
               free_in       = free_ff + 1'b1;
               rsp_status_in = bba_pkg::ST_OK;
               rsp_free_in   = free_ff + 1'b1;
            end
         end

         default: begin
            state_in = bba_pkg::S_IDLE;
         end
      endcase
   end

   // control and config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bba_pkg::S_IDLE;
         free_ff       <= bba_pkg::eff_count(bba_pkg::COUNT_RESET);
         base_ff       <= bba_pkg::BASE_RESET;
         bytes_ff      <= bba_pkg::BYTES_RESET;
         count_ff      <= bba_pkg::COUNT_RESET;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         free_ff       <= free_in;
         base_ff       <= base_in;
         bytes_ff      <= bytes_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // request and response payload
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      addr_ff       <= addr_in;
      row_ff        <= row_in;
      idx_ff        <= idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_free_ff   <= rsp_free_in;
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_block_address = rsp_addr_ff;
   assign rsp_free_blocks   = rsp_free_ff;

   // a taken request holds the block busy
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request taken but block not busy");

   // only an ok allocation carries an address
   a_fail_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status_ff != bba_pkg::ST_OK)) |-> (rsp_block_address == '0))
      else $error("failed request returned an address");

   // free count never exceeds the pool size
   a_free_range: assert property (@(posedge clock) disable iff (reset)
      free_ff <= cnt_eff)
      else $error("free count above block count");

   // arithmetic results only arrive while the sequencer waits for them
   a_arith_done: assert property (@(posedge clock) disable iff (reset)
      arith_rsp.done |-> ((state_ff == bba_pkg::S_MUL_WAIT) ||
                          (state_ff == bba_pkg::S_DIV_WAIT)))
      else $error("arithmetic done outside a wait state");

   // the response strobe lands with the sequencer back at idle
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response strobe while busy");

endmodule

// File: rtl/bba_arith.sv
// Shared shift-add / shift-subtract unit: radix-2 multiply and divide
module bba_arith (
   input  logic                   clock,
   input  logic                   reset,
   input  bba_pkg::arith_req_type req,
   output bba_pkg::arith_rsp_type rsp
);

   logic                                run_ff, run_in;
   logic                                done_ff, done_in;
   bba_pkg::arith_op_type               op_ff, op_in;
   logic [bba_pkg::STEP_W-1:0]          cnt_ff, cnt_in;
   logic [bba_pkg::ADDR_W-1:0]          acc_ff, acc_in;
   logic [bba_pkg::ADDR_W-1:0]          a_ff, a_in;
   logic [bba_pkg::BYTES_W-1:0]         b_ff, b_in;
   logic [bba_pkg::BYTES_W-1:0]         rem_ff, rem_in;

   // the one adder everything goes through
   logic [bba_pkg::ADDR_W:0]            opx, opy, sum;
   logic                                sub;
   logic                                borrow;

   always_comb begin
      if (op_ff == bba_pkg::OP_DIV) begin
         opx = (bba_pkg::ADDR_W+1)'({rem_ff, acc_ff[bba_pkg::ADDR_W-1]});
         opy = (bba_pkg::ADDR_W+1)'(b_ff);
         sub = 1'b1;
      end else begin
         opx = {1'b0, acc_ff[bba_pkg::ADDR_W-2:0], 1'b0};
         opy = b_ff[bba_pkg::BYTES_W-1] ? {1'b0, a_ff} : '0;
         sub = 1'b0;
      end
      sum    = sub ? (opx - opy) : (opx + opy);
      borrow = sum[bba_pkg::ADDR_W];
   end

   // step control
   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      rem_in  = rem_ff;
      if (req.start) begin
         run_in = 1'b1;
         op_in  = req.op;
         a_in   = req.a;
         b_in   = req.b;
         rem_in = '0;
         if (req.op == bba_pkg::OP_DIV) begin
            cnt_in = bba_pkg::STEP_W'(bba_pkg::ADDR_W - 1);
            acc_in = req.a;
         end else begin
            cnt_in = bba_pkg::STEP_W'(bba_pkg::BYTES_W - 1);
            acc_in = '0;
         end
      end else if (run_ff) begin
         if (op_ff == bba_pkg::OP_DIV) begin
            // restoring division, quotient shifts in behind the dividend
            rem_in = borrow ? opx[bba_pkg::BYTES_W-1:0] : sum[bba_pkg::BYTES_W-1:0];
            acc_in = {acc_ff[bba_pkg::ADDR_W-2:0], ~borrow};
         end else begin
            // multiplier bits consumed msb first
            acc_in = sum[bba_pkg::ADDR_W-1:0];
            b_in   = {b_ff[bba_pkg::BYTES_W-2:0], 1'b0};
         end
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         op_ff   <= bba_pkg::OP_MUL;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         op_ff   <= op_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      rem_ff <= rem_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.result = acc_ff;
   assign rsp.rem    = rem_ff;

endmodule

// File: rtl/bba_map.sv
// Occupancy map: rows of bits in a memory, row valid and row full flags
module bba_map (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         clear,
   input  bba_pkg::map_rd_type          rd,
   input  bba_pkg::map_wr_type          wr,
   output logic [bba_pkg::WORD_W-1:0]   rd_data,
   output logic [bba_pkg::ROW_W-1:0]    free_row
);

   logic [bba_pkg::WORD_W-1:0] mem [bba_pkg::ROWS];
   logic [bba_pkg::WORD_W-1:0] rd_data_ff;
   logic                       rd_valid_ff;
   logic [bba_pkg::ROWS-1:0]   row_valid_ff;
   logic [bba_pkg::ROWS-1:0]   row_full_ff;

   // memory array, registered read
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.row] <= wr.data;
      end
      if (rd.en) begin
         rd_data_ff <= mem[rd.row];
      end
   end

   // per-row flags; a row never written reads as all free
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         row_valid_ff <= '0;
         row_full_ff  <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         if (wr.en) begin
            row_valid_ff[wr.row] <= 1'b1;
            row_full_ff[wr.row]  <= &wr.data;
         end
         if (rd.en) begin
            rd_valid_ff <= row_valid_ff[rd.row];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

   // lowest row that still has a free bit
   always_comb begin
      free_row = '0;
      for (int i = bba_pkg::ROWS - 1; i >= 0; i--) begin
         if (!row_full_ff[i]) begin
            free_row = bba_pkg::ROW_W'(i);
         end
      end
   end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

   // Register index with no register behind it
   localparam logic [bba_pkg::CSR_IDX_W-1:0] CSR_SPARE = bba_pkg::CSR_IDX_W'(3);
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int DRAIN_CYCLES    = 40;
   localparam int PHASES          = 12;
   localparam int PHASE_REQUESTS  = 152;

   typedef struct {
      bba_pkg::status_type         status;
      logic [bba_pkg::ADDR_W-1:0]  block_address;
      logic [bba_pkg::COUNT_W-1:0] free_blocks;
   } pool_rsp_type;

   // Shadow of the pool: occupancy, free count and the responses still due
   class pool_tracker;
      logic [bba_pkg::ADDR_W-1:0]  pool_base;
      logic [bba_pkg::BYTES_W-1:0] size_reg;
      logic [bba_pkg::COUNT_W-1:0] count_reg;
      bit                          used [bba_pkg::MAX_BLOCKS];
      logic [bba_pkg::COUNT_W-1:0] free_left;
      pool_rsp_type                pending [$];
      int                          errors;
      int                          requests;
      int                          reg_writes;
      int                          status_hits [6];

      function new();
         pool_base = bba_pkg::BASE_RESET;
         size_reg  = bba_pkg::BYTES_RESET;
         count_reg = bba_pkg::COUNT_RESET;
         clear_pool();
      endfunction

      // count above capacity clamps to capacity
      function int unsigned live_count();
         return (count_reg > bba_pkg::MAX_BLOCKS) ? bba_pkg::MAX_BLOCKS : int'(count_reg);
      endfunction

      // zero size acts as one byte
      function int unsigned live_size();
         return (size_reg == '0) ? 1 : int'(size_reg);
      endfunction

      function void clear_pool();
         foreach (used[i]) used[i] = 1'b0;
         free_left = bba_pkg::COUNT_W'(live_count());
      endfunction

      function logic [bba_pkg::ADDR_W-1:0] block_start(input int unsigned i);
         return pool_base + bba_pkg::ADDR_W'(i * live_size());
      endfunction

      // random block in use, -1 when the pool is empty
      function int pick_used();
         int unsigned lim;
         int unsigned first;
         lim = live_count();
         if (lim == 0) return -1;
         first = $urandom_range(lim - 1);
         for (int unsigned k = 0; k < lim; k++)
            if (used[(first + k) % lim]) return (first + k) % lim;
         return -1;
      endfunction

      // any write to a real register empties the pool
      function void apply_register(input logic [bba_pkg::CSR_IDX_W-1:0] idx,
                                   input logic [bba_pkg::ADDR_W-1:0] data);
         reg_writes++;
         case (idx)
            bba_pkg::CSR_BASE:  pool_base = data;
            bba_pkg::CSR_BYTES: size_reg  = data[bba_pkg::BYTES_W-1:0];
            bba_pkg::CSR_COUNT: count_reg = data[bba_pkg::COUNT_W-1:0];
            default:            return;
         endcase
         clear_pool();
      endfunction

      // work out the response to an accepted request
      function void note_request(input logic cmd, input logic [bba_pkg::ADDR_W-1:0] addr);
         pool_rsp_type    r;
         int unsigned     lim;
         int unsigned     sz;
         int unsigned     off;
         int unsigned     idx;
         longint unsigned span;
         lim = live_count();
         sz  = live_size();
         r.status = bba_pkg::ST_OK;
         r.block_address = '0;
         requests++;
         if (cmd == bba_pkg::CMD_ALLOC) begin
            r.status = bba_pkg::ST_FULL;
            if (free_left != 0) begin
               for (int unsigned i = 0; i < lim; i++) begin
                  if (!used[i]) begin
                     used[i] = 1'b1;
                     free_left = free_left - 1'b1;
                     r.block_address = block_start(i);
                     r.status = bba_pkg::ST_OK;
                     break;
                  end
               end
            end
         end else begin
            // checks in order: zero, outside, misaligned, already free
            span = longint'(lim) * longint'(sz);
            if (addr == '0) begin
               r.status = bba_pkg::ST_ZERO;
            end else if (addr < pool_base) begin
               r.status = bba_pkg::ST_OUTSIDE;
            end else begin
               off = addr - pool_base;
               if (longint'(off) >= span) begin
                  r.status = bba_pkg::ST_OUTSIDE;
               end else if (off % sz != 0) begin
                  r.status = bba_pkg::ST_MISALIGNED;
               end else begin
                  idx = off / sz;
                  if (idx >= lim || !used[idx]) begin
                     r.status = bba_pkg::ST_ALREADY_FREE;
                  end else begin
                     used[idx] = 1'b0;
                     free_left = free_left + 1'b1;
                  end
               end
            end
         end
         r.free_blocks = free_left;
         pending.push_back(r);
      endfunction

      // compare a response with the oldest one due
      function void check_response(input logic [bba_pkg::STATUS_W-1:0] status,
                                   input logic [bba_pkg::ADDR_W-1:0] addr,
                                   input logic [bba_pkg::COUNT_W-1:0] free_cnt);
         pool_rsp_type want;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("%0t: response with no request outstanding (status %0d)",
                        $time, status);
            return;
         end
         want = pending.pop_front();
         status_hits[want.status]++;
         if (status !== want.status || addr !== want.block_address ||
             free_cnt !== want.free_blocks) begin
            errors++;
            if (errors <= 10)
               $display("%0t: mismatch status %0d/%0d addr %h/%h free %0d/%0d (exp/got)",
                        $time, want.status, status, want.block_address, addr,
                        want.free_blocks, free_cnt);
         end
      endfunction
   endclass

   logic                          clock       = 1'b0;
   logic                          reset       = 1'b1;
   logic                          start       = 1'b0;
   logic                          req_cmd     = bba_pkg::CMD_ALLOC;
   logic [bba_pkg::ADDR_W-1:0]    req_address = '0;
   logic                          csr_valid   = 1'b0;
   logic [bba_pkg::CSR_IDX_W-1:0] csr_index   = bba_pkg::CSR_BASE;
   logic [bba_pkg::ADDR_W-1:0]    csr_wdata   = '0;
   logic                          busy;
   logic                          rsp_strobe;
   logic [bba_pkg::STATUS_W-1:0]  rsp_status;
   logic [bba_pkg::ADDR_W-1:0]    rsp_block_address;
   logic [bba_pkg::COUNT_W-1:0]   rsp_free_blocks;
   logic                          csr_ready;

   pool_tracker pool = new();
   int          send_idle_pct = 0;
   int          quiet_cycles  = 0;

   bitmap_block_allocator u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_cmd           (req_cmd),
      .req_address       (req_address),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_block_address (rsp_block_address),
      .rsp_free_blocks   (rsp_free_blocks),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         pool.check_response(rsp_status, rsp_block_address, rsp_free_blocks);
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: %0d cycles without a handshake", quiet_cycles);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // start stays high on return so back-to-back requests keep it asserted
   task automatic issue(input logic cmd, input logic [bba_pkg::ADDR_W-1:0] addr);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      start       <= 1'b1;
      req_cmd     <= cmd;
      req_address <= addr;
      do @(posedge clock); while (!(start && !busy));
      pool.note_request(cmd, addr);
   endtask

   // csr_valid stays high on return; caller drops it after the last write
   task automatic csr_write(input logic [bba_pkg::CSR_IDX_W-1:0] idx,
                            input logic [bba_pkg::ADDR_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      pool.apply_register(idx, data);
   endtask

   // stop requesting and wait for every response due
   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (pool.pending.size() != 0) @(posedge clock);
   endtask

   // new pool geometry, extremes weighted in
   task automatic random_setup();
      logic [bba_pkg::ADDR_W-1:0]  base_val;
      logic [bba_pkg::BYTES_W-1:0] size_val;
      logic [bba_pkg::COUNT_W-1:0] count_val;
      case ($urandom_range(3))
         0:       base_val = '0;
         1:       base_val = $urandom;
         2:       base_val = 32'hFFFF_F000 + $urandom_range(4095);
         default: base_val = $urandom_range(1, 4096);
      endcase
      case ($urandom_range(4))
         0:       size_val = '0;
         1:       size_val = '1;
         2:       size_val = bba_pkg::BYTES_W'($urandom_range(1, 16));
         3:       size_val = bba_pkg::BYTES_W'($urandom_range(1, 256));
         default: size_val = bba_pkg::BYTES_W'($urandom);
      endcase
      case ($urandom_range(5))
         0:       count_val = '0;
         1:       count_val = bba_pkg::COUNT_W'(bba_pkg::MAX_BLOCKS);
         2:       count_val = bba_pkg::COUNT_W'($urandom_range(bba_pkg::MAX_BLOCKS + 1, 2047));
         default: count_val = bba_pkg::COUNT_W'($urandom_range(1, 24));
      endcase
      if ($urandom_range(3) != 0) csr_write(bba_pkg::CSR_BASE, base_val);
      if ($urandom_range(3) != 0) csr_write(bba_pkg::CSR_BYTES, {16'($urandom), size_val});
      if ($urandom_range(3) == 0) csr_write(CSR_SPARE, $urandom);
      csr_write(bba_pkg::CSR_COUNT, {21'($urandom), count_val});
      csr_valid <= 1'b0;
   endtask

   // mostly allocations and frees of live blocks, the rest bad addresses
   task automatic random_request();
      int unsigned                lim;
      int unsigned                sz;
      int unsigned                idx;
      int                         live;
      int unsigned                roll;
      logic [bba_pkg::ADDR_W-1:0] addr;
      lim  = pool.live_count();
      sz   = pool.live_size();
      idx  = (lim == 0) ? 0 : $urandom_range(lim - 1);
      live = pool.pick_used();
      roll = $urandom_range(99);
      if (roll < 45 || (roll < 80 && live < 0)) begin
         issue(bba_pkg::CMD_ALLOC, $urandom);
      end else if (roll < 80) begin
         issue(bba_pkg::CMD_FREE, pool.block_start(live));
      end else begin
         case ($urandom_range(5))
            0:       addr = '0;
            1:       addr = $urandom;
            2:       addr = (sz > 1) ? pool.block_start(idx) + $urandom_range(1, sz - 1)
                                     : $urandom;
            3:       addr = pool.block_start(idx);
            4:       addr = pool.block_start(lim) + $urandom_range(0, 1);
            default: addr = pool.pool_base - 1;
         endcase
         issue(bba_pkg::CMD_FREE, addr);
      end
   endtask

   initial begin
      int idle_levels [3];
      idle_levels = '{0, 55, 31};

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset geometry: base 0, 32-byte blocks, 1024 blocks
      issue(bba_pkg::CMD_ALLOC, '1);
      issue(bba_pkg::CMD_ALLOC, '0);
      issue(bba_pkg::CMD_FREE, '0);               // zero address even with base 0
      issue(bba_pkg::CMD_FREE, 32'd32);
      issue(bba_pkg::CMD_FREE, 32'd32);           // already free
      issue(bba_pkg::CMD_FREE, 32'd33);           // misaligned
      issue(bba_pkg::CMD_FREE, 32'd32768);        // one past the end
      issue(bba_pkg::CMD_FREE, '1);
      settle();

      // write to the unused index must not empty the pool
      csr_write(CSR_SPARE, '1);
      csr_valid <= 1'b0;
      issue(bba_pkg::CMD_ALLOC, '0);
      settle();

      // pool at the top of the address space: allocations wrap past zero
      csr_write(bba_pkg::CSR_BASE, 32'hFFFF_FFF0);
      csr_write(bba_pkg::CSR_BYTES, 32'hABCD_0008);
      csr_write(bba_pkg::CSR_COUNT, 32'd4);
      csr_valid <= 1'b0;
      repeat (5) issue(bba_pkg::CMD_ALLOC, $urandom);
      issue(bba_pkg::CMD_FREE, 32'hFFFF_FFF4);    // misaligned
      issue(bba_pkg::CMD_FREE, 32'h0000_0008);    // wrapped block lies below base
      issue(bba_pkg::CMD_FREE, 32'hFFFF_FFF8);
      settle();

      // empty pool
      csr_write(bba_pkg::CSR_BASE, 32'h0000_0100);
      csr_write(bba_pkg::CSR_COUNT, 32'd0);
      csr_valid <= 1'b0;
      issue(bba_pkg::CMD_ALLOC, '0);
      issue(bba_pkg::CMD_FREE, 32'h0000_0100);
      settle();

      // widest blocks, count above capacity clamps
      csr_write(bba_pkg::CSR_BYTES, 32'h0000_FFFF);
      csr_write(bba_pkg::CSR_COUNT, 32'h0000_07FF);
      csr_valid <= 1'b0;
      issue(bba_pkg::CMD_ALLOC, '0);
      issue(bba_pkg::CMD_FREE, 32'h0000_0100 + 32'd1023 * 32'd65535);
      issue(bba_pkg::CMD_FREE, 32'h0000_0100 + 32'd1024 * 32'd65535);
      settle();

      // zero block size acts as one byte
      csr_write(bba_pkg::CSR_BYTES, 32'h0000_0000);
      csr_valid <= 1'b0;
      issue(bba_pkg::CMD_ALLOC, '0);
      issue(bba_pkg::CMD_ALLOC, '0);
      issue(bba_pkg::CMD_FREE, 32'h0000_0101);
      settle();

      // random phases, each with its own geometry and idle rate
      for (int p = 0; p < PHASES; p++) begin
         send_idle_pct = idle_levels[p % 3];
         random_setup();
         repeat (PHASE_REQUESTS) random_request();
         settle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pool.pending.size() != 0) begin
         pool.errors++;
         $display("%0d responses never arrived", pool.pending.size());
      end
      $display("Ran %0d requests across %0d register writes and %0d random pools",
               pool.requests, pool.reg_writes, PHASES);
      $display("Responses: ok %0d, full %0d, zero %0d, outside %0d, misaligned %0d, free %0d",
               pool.status_hits[bba_pkg::ST_OK], pool.status_hits[bba_pkg::ST_FULL],
               pool.status_hits[bba_pkg::ST_ZERO], pool.status_hits[bba_pkg::ST_OUTSIDE],
               pool.status_hits[bba_pkg::ST_MISALIGNED],
               pool.status_hits[bba_pkg::ST_ALREADY_FREE]);
      if (pool.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// File: bitmap_block_allocator.f
rtl/bba_pkg.sv
rtl/bba_arith.sv
rtl/bba_map.sv
rtl/bitmap_block_allocator.sv
sim/testbench.sv
